// ===== rtl/uvs_pkg.sv =====
// ----------------------------------------------------------------------------
// uvs_pkg: shared types and constants of the UV sphere cell vertex generator
// Item structures, configuration register indexes, sine coefficients and the
// vertex selection table of the cell sequencer.
// ----------------------------------------------------------------------------
package uvs_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int MAX_BANDS     = 256;
    localparam int MAX_MERIDIANS = 256;
    localparam int IDX_W         = 8;
    localparam int CNT_W         = 9;
    localparam int QUO_W         = ANGLE_BITS + 1;
    localparam int DIV_STEPS     = ANGLE_BITS;
    localparam int SIN_STAGES    = 6;
    localparam int STEP_W        = 3;

    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    localparam logic [30:0] SIN_C0 = 31'd1686629713;
    localparam logic [30:0] SIN_C1 = 31'd693598668;
    localparam logic [30:0] SIN_C2 = 31'd85569306;
    localparam logic [30:0] SIN_C3 = 31'd5026995;
    localparam logic [30:0] SIN_C4 = 31'd172275;

    localparam logic [2:0] CFG_CENTER_X  = 3'd0;
    localparam logic [2:0] CFG_CENTER_Y  = 3'd1;
    localparam logic [2:0] CFG_CENTER_Z  = 3'd2;
    localparam logic [2:0] CFG_RADIUS    = 3'd3;
    localparam logic [2:0] CFG_BANDS     = 3'd4;
    localparam logic [2:0] CFG_MERIDIANS = 3'd5;

    typedef struct packed {
        logic [IDX_W-1:0] band_index;
        logic [IDX_W-1:0] meridian_index;
    } req_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               dark_shade;
        logic               last_vertex;
        logic               index_error;
    } vtx_item_t;

    typedef struct packed {
        logic valid;
        logic err;
        logic pole;
        logic south;
        logic dark;
        logic last;
    } tag_t;

    typedef struct packed {
        logic [CNT_W-1:0] lat_rem;
        logic [CNT_W-1:0] lon_rem;
        logic [QUO_W-1:0] lat_quo;
        logic [QUO_W-1:0] lon_quo;
    } quo_t;

    typedef enum logic [1:0] {
        KIND_ERR,
        KIND_NORTH,
        KIND_SOUTH,
        KIND_MID
    } kind_t;

    typedef struct packed {
        logic db;
        logic dm;
        logic last;
        logic pole;
    } vsel_t;

    function automatic vsel_t vtx_select(kind_t kind, logic [STEP_W-1:0] k);
        vsel_t s;
        s = '{db: 1'b0, dm: 1'b0, last: 1'b1, pole: 1'b0};
        unique case (kind)
            KIND_ERR: s.last = 1'b1;
            KIND_NORTH:
            begin
                s.last = (k == 3'd2);
                s.pole = (k == 3'd0);
                s.db   = (k != 3'd0);
                s.dm   = (k == 3'd2);
            end
            KIND_SOUTH:
            begin
                s.last = (k == 3'd2);
                s.pole = (k == 3'd0);
                s.dm   = (k == 3'd1);
            end
            KIND_MID:
            begin
                s.last = (k == 3'd5);
                s.db   = (k == 3'd1) || (k == 3'd4) || (k == 3'd5);
                s.dm   = (k == 3'd2) || (k == 3'd3) || (k == 3'd5);
            end
            default: s.last = 1'b1;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/uvs_div_cell.sv =====
// ----------------------------------------------------------------------------
// uvs_div_cell: one restoring division step for the latitude and longitude
// Each cell adds one quotient bit to both lanes and hands the remainders on.
// ----------------------------------------------------------------------------
module uvs_div_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic [uvs_pkg::CNT_W-1:0]       bands,
    input  logic [uvs_pkg::CNT_W-1:0]       meridians,
    input  uvs_pkg::tag_t                   tag_in,
    input  uvs_pkg::quo_t                   quo_in,
    output uvs_pkg::tag_t                   tag_out,
    output uvs_pkg::quo_t                   quo_out
);

    uvs_pkg::tag_t            tag_reg;
    uvs_pkg::tag_t            tag_next;
    uvs_pkg::quo_t            quo_reg;
    uvs_pkg::quo_t            quo_next;
    logic [uvs_pkg::CNT_W:0]  lat_sh;
    logic [uvs_pkg::CNT_W:0]  lon_sh;
    logic                     lat_ge;
    logic                     lon_ge;

    always_comb
    begin
        tag_next = tag_in;
        lat_sh   = {quo_in.lat_rem, 1'b0};
        lon_sh   = {quo_in.lon_rem, 1'b0};
        lat_ge   = lat_sh >= {1'b0, bands};
        lon_ge   = lon_sh >= {1'b0, meridians};
        quo_next.lat_rem = lat_ge ? uvs_pkg::CNT_W'(lat_sh - {1'b0, bands})
                                  : lat_sh[uvs_pkg::CNT_W-1:0];
        quo_next.lon_rem = lon_ge ? uvs_pkg::CNT_W'(lon_sh - {1'b0, meridians})
                                  : lon_sh[uvs_pkg::CNT_W-1:0];
        quo_next.lat_quo = {quo_in.lat_quo[uvs_pkg::QUO_W-2:0], lat_ge};
        quo_next.lon_quo = {quo_in.lon_quo[uvs_pkg::QUO_W-2:0], lon_ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (en)
        begin
            tag_reg <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= quo_next;
        end
    end

    assign tag_out = tag_reg;
    assign quo_out = quo_reg;

endmodule

// ===== rtl/uvs_sine.sv =====
// ----------------------------------------------------------------------------
// uvs_sine: pipelined Q1.15 sine of a fraction-of-a-turn phase
// Quarter-wave folding, then a Horner evaluation of the odd Taylor series
// with one multiplication per stage, rounded and clamped at the end.
// ----------------------------------------------------------------------------
module uvs_sine (
    input  logic                              clk,
    input  logic                              en,
    input  logic [uvs_pkg::ANGLE_BITS-1:0]    phase,
    output logic signed [15:0]                sine
);

    localparam logic [30:0] ONE = 31'h4000_0000;

    function automatic logic [31:0] mul_q30(logic [30:0] a, logic [30:0] b);
        logic [61:0] p;
        p = 62'(a) * 62'(b);
        return p[61:30];
    endfunction

    logic [1:0]  quad;
    logic [30:0] x_lin;
    logic [30:0] x_fold;
    logic [31:0] x_sq;
    logic [31:0] s_raw;
    logic [32:0] s_rnd;
    logic [17:0] s_q;
    logic [15:0] s_mag;

    logic [30:0] xa_reg, xb_reg, xc_reg, xd_reg, xe_reg;
    logic        na_reg, nb_reg, nc_reg, nd_reg, ne_reg;
    logic [30:0] x2a_reg, x2b_reg, x2c_reg, x2d_reg;
    logic [30:0] tb_reg, tc_reg, td_reg, te_reg;
    logic signed [15:0] sine_reg;
    logic signed [15:0] sine_next;

    always_comb
    begin
        quad   = phase[uvs_pkg::ANGLE_BITS-1:uvs_pkg::ANGLE_BITS-2];
        x_lin  = 31'(phase[uvs_pkg::ANGLE_BITS-3:0]) << (32 - uvs_pkg::ANGLE_BITS);
        x_fold = quad[0] ? 31'(ONE - x_lin) : x_lin;
        x_sq   = mul_q30(x_fold, x_fold);
        s_raw  = mul_q30(xe_reg, te_reg);
        s_rnd  = 33'(s_raw) + 33'd16384;
        s_q    = s_rnd[32:15];
        s_mag  = (s_q > 18'd32767) ? 16'd32767 : s_q[15:0];
        sine_next = ne_reg ? -$signed(s_mag) : $signed(s_mag);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xa_reg   <= x_fold;
            na_reg   <= quad[1];
            x2a_reg  <= x_sq[30:0];
            xb_reg   <= xa_reg;
            nb_reg   <= na_reg;
            x2b_reg  <= x2a_reg;
            tb_reg   <= 31'({1'b0, uvs_pkg::SIN_C3} - mul_q30(x2a_reg, uvs_pkg::SIN_C4));
            xc_reg   <= xb_reg;
            nc_reg   <= nb_reg;
            x2c_reg  <= x2b_reg;
            tc_reg   <= 31'({1'b0, uvs_pkg::SIN_C2} - mul_q30(x2b_reg, tb_reg));
            xd_reg   <= xc_reg;
            nd_reg   <= nc_reg;
            x2d_reg  <= x2c_reg;
            td_reg   <= 31'({1'b0, uvs_pkg::SIN_C1} - mul_q30(x2c_reg, tc_reg));
            xe_reg   <= xd_reg;
            ne_reg   <= nd_reg;
            te_reg   <= 31'({1'b0, uvs_pkg::SIN_C0} - mul_q30(x2d_reg, td_reg));
            sine_reg <= sine_next;
        end
    end

    assign sine = sine_reg;

endmodule

// ===== rtl/uvs_scale.sv =====
// ----------------------------------------------------------------------------
// uvs_scale: vertex position arithmetic and result register
// Forms the direction products, scales by the radius with rounding, adds
// the centre with saturation and selects the pole and error results.
// ----------------------------------------------------------------------------
module uvs_scale (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  uvs_pkg::tag_t        tag_in,
    input  logic signed [15:0]   sin_lat,
    input  logic signed [15:0]   cos_lat,
    input  logic signed [15:0]   sin_lon,
    input  logic signed [15:0]   cos_lon,
    input  logic signed [31:0]   center_x,
    input  logic signed [31:0]   center_y,
    input  logic signed [31:0]   center_z,
    input  logic [30:0]          radius,
    output logic                 valid,
    output uvs_pkg::vtx_item_t   item
);

    function automatic logic signed [32:0] round_shift(logic signed [63:0] p, int sh);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] sum;
        logic [31:0] r;
        neg = p[63];
        mag = neg ? 64'(-p) : 64'(p);
        sum = mag + (64'd1 << (sh - 1));
        r   = 32'(sum >> sh);
        return neg ? -$signed({1'b0, r}) : $signed({1'b0, r});
    endfunction

    function automatic logic [31:0] sat32(logic signed [33:0] v);
        if (v > 34'sd2147483647)
        begin
            return 32'h7FFF_FFFF;
        end
        else if (v < -34'sd2147483648)
        begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [33:0] add_center(logic signed [31:0] c,
                                                      logic signed [32:0] f);
        return $signed({{2{c[31]}}, c}) + $signed({f[32], f});
    endfunction

    uvs_pkg::tag_t      t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [31:0] p1x_reg, p1z_reg;
    logic signed [15:0] p1y_reg;
    logic signed [63:0] m2x_reg, m2y_reg, m2z_reg;
    logic signed [63:0] m2x_next, m2y_next, m2z_next;
    logic signed [32:0] f3x_reg, f3y_reg, f3z_reg;
    logic signed [31:0] rad_s;
    logic signed [33:0] pole_y;
    uvs_pkg::vtx_item_t item_reg;
    uvs_pkg::vtx_item_t item_next;

    always_comb
    begin
        rad_s    = $signed({1'b0, radius});
        m2x_next = rad_s * p1x_reg;
        m2y_next = rad_s * $signed({{16{p1y_reg[15]}}, p1y_reg});
        m2z_next = rad_s * p1z_reg;
        pole_y   = t3_reg.south
                 ? $signed({{2{center_y[31]}}, center_y}) - $signed({3'b000, radius})
                 : $signed({{2{center_y[31]}}, center_y}) + $signed({3'b000, radius});

        item_next.dark_shade  = t3_reg.dark;
        item_next.last_vertex = t3_reg.last;
        item_next.index_error = 1'b0;
        if (t3_reg.err)
        begin
            item_next.pos_x       = '0;
            item_next.pos_y       = '0;
            item_next.pos_z       = '0;
            item_next.dark_shade  = 1'b0;
            item_next.last_vertex = 1'b1;
            item_next.index_error = 1'b1;
        end
        else if (t3_reg.pole)
        begin
            item_next.pos_x = center_x;
            item_next.pos_y = $signed(sat32(pole_y));
            item_next.pos_z = center_z;
        end
        else
        begin
            item_next.pos_x = $signed(sat32(add_center(center_x, f3x_reg)));
            item_next.pos_y = $signed(sat32(add_center(center_y, f3y_reg)));
            item_next.pos_z = $signed(sat32(add_center(center_z, f3z_reg)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg <= '0;
            t2_reg <= '0;
            t3_reg <= '0;
            t4_reg <= '0;
        end
        else if (en)
        begin
            t1_reg <= tag_in;
            t2_reg <= t1_reg;
            t3_reg <= t2_reg;
            t4_reg <= t3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1x_reg  <= cos_lat * cos_lon;
            p1z_reg  <= cos_lat * sin_lon;
            p1y_reg  <= sin_lat;
            m2x_reg  <= m2x_next;
            m2y_reg  <= m2y_next;
            m2z_reg  <= m2z_next;
            f3x_reg  <= round_shift(m2x_reg, 30);
            f3y_reg  <= round_shift(m2y_reg, 15);
            f3z_reg  <= round_shift(m2z_reg, 30);
            item_reg <= item_next;
        end
    end

    assign valid = t4_reg.valid;
    assign item  = item_reg;

endmodule

// ===== rtl/uv_sphere_cell_vertex_generator.sv =====
// ----------------------------------------------------------------------------
// uv_sphere_cell_vertex_generator: triangle vertices of one UV sphere cell
// Top level with configuration registers, cell sequencer, divider chain,
// sine units and position arithmetic.
// ----------------------------------------------------------------------------
// A request item (band_index, meridian_index) enters on req_valid/req_stall.
// The block answers with vertex items on vtx_valid/vtx_stall: three for a
// polar cap cell, six for a middle band cell and a single error item for an
// index or count out of range. The final vertex of each cell carries
// last_vertex.
// The sequencer issues one vertex per cycle, unless the receiver stalls,
// into a pipeline of sixteen division cells, six sine stages and four
// arithmetic stages. A new request is taken in the cycle the previous one
// issues its last vertex.
// When the receiver stalls, the whole pipeline and the sequencer hold, and
// req_stall rises once the sequencer has an item waiting.
// Reset empties the pipeline and loads the default configuration: centre at
// the origin, radius 1.0, 16 bands and 32 meridians. Configuration is
// written on cfg_we and must only change while the block is idle.
// ----------------------------------------------------------------------------
module uv_sphere_cell_vertex_generator (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  uvs_pkg::req_item_t   req_item,
    output logic                 vtx_valid,
    input  logic                 vtx_stall,
    output uvs_pkg::vtx_item_t   vtx_item,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int CW = uvs_pkg::CNT_W;
    localparam int AW = uvs_pkg::ANGLE_BITS;

    logic signed [31:0]            center_x_reg, center_y_reg, center_z_reg;
    logic [30:0]                   radius_reg;
    logic [CW-1:0]                 bands_reg, meridians_reg;

    logic                          busy_reg, busy_next;
    logic [uvs_pkg::STEP_W-1:0]    k_reg, k_next;
    uvs_pkg::kind_t                kind_reg, kind_next;
    logic [uvs_pkg::IDX_W-1:0]     b_reg, m_reg;
    logic                          dark_reg, dark_next;

    logic                          en, emit, fin, accept, bad;
    uvs_pkg::vsel_t                sel;
    logic [CW-1:0]                 vb, vm;
    logic                          lat_q0, lon_q0;

    uvs_pkg::tag_t                 head_tag;
    uvs_pkg::quo_t                 head_quo;
    uvs_pkg::tag_t                 cell_tag [uvs_pkg::DIV_STEPS+1];
    uvs_pkg::quo_t                 cell_quo [uvs_pkg::DIV_STEPS+1];
    uvs_pkg::tag_t                 sin_tag_reg [uvs_pkg::SIN_STAGES];

    logic [AW-1:0]                 lat_ph, lon_ph;
    logic signed [15:0]            sin_lat, cos_lat, sin_lon, cos_lon;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            center_z_reg  <= '0;
            radius_reg    <= 31'd65536;
            bands_reg     <= 9'd16;
            meridians_reg <= 9'd32;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                uvs_pkg::CFG_CENTER_X:  center_x_reg  <= $signed(cfg_data);
                uvs_pkg::CFG_CENTER_Y:  center_y_reg  <= $signed(cfg_data);
                uvs_pkg::CFG_CENTER_Z:  center_z_reg  <= $signed(cfg_data);
                uvs_pkg::CFG_RADIUS:    radius_reg    <= cfg_data[30:0];
                uvs_pkg::CFG_BANDS:     bands_reg     <= cfg_data[CW-1:0];
                uvs_pkg::CFG_MERIDIANS: meridians_reg <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        en     = !(vtx_valid && vtx_stall);
        sel    = uvs_pkg::vtx_select(kind_reg, k_reg);
        emit   = busy_reg && en;
        fin    = emit && sel.last;
        req_stall = busy_reg && !fin;
        accept = req_valid && !req_stall;

        bad = (bands_reg < 9'd2) || (bands_reg > CW'(uvs_pkg::MAX_BANDS))
           || (meridians_reg < 9'd3) || (meridians_reg > CW'(uvs_pkg::MAX_MERIDIANS))
           || ({1'b0, req_item.band_index} >= bands_reg)
           || ({1'b0, req_item.meridian_index} >= meridians_reg);
        if (bad)
        begin
            kind_next = uvs_pkg::KIND_ERR;
        end
        else if (req_item.band_index == '0)
        begin
            kind_next = uvs_pkg::KIND_NORTH;
        end
        else if ({1'b0, req_item.band_index} == CW'(bands_reg - 9'd1))
        begin
            kind_next = uvs_pkg::KIND_SOUTH;
        end
        else
        begin
            kind_next = uvs_pkg::KIND_MID;
        end
        if (kind_next == uvs_pkg::KIND_MID)
        begin
            dark_next = !(req_item.band_index[0] ^ req_item.meridian_index[0]);
        end
        else
        begin
            dark_next = !req_item.meridian_index[0];
        end

        busy_next = busy_reg;
        k_next    = k_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            k_next    = '0;
        end
        else if (fin)
        begin
            busy_next = 1'b0;
            k_next    = '0;
        end
        else if (emit)
        begin
            k_next = k_reg + 3'd1;
        end

        vb     = {1'b0, b_reg} + CW'(sel.db);
        vm     = {1'b0, m_reg} + CW'(sel.dm);
        lat_q0 = vb >= bands_reg;
        lon_q0 = vm >= meridians_reg;
        head_quo.lat_rem = lat_q0 ? CW'(vb - bands_reg) : vb;
        head_quo.lon_rem = lon_q0 ? CW'(vm - meridians_reg) : vm;
        head_quo.lat_quo = uvs_pkg::QUO_W'(lat_q0);
        head_quo.lon_quo = uvs_pkg::QUO_W'(lon_q0);
        head_tag.valid = emit;
        head_tag.err   = (kind_reg == uvs_pkg::KIND_ERR);
        head_tag.pole  = sel.pole;
        head_tag.south = (kind_reg == uvs_pkg::KIND_SOUTH);
        head_tag.dark  = dark_reg;
        head_tag.last  = sel.last;
    end

    assign cell_tag[0] = head_tag;
    assign cell_quo[0] = head_quo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind_next;
            b_reg    <= req_item.band_index;
            m_reg    <= req_item.meridian_index;
            dark_reg <= dark_next;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < uvs_pkg::DIV_STEPS; gi++)
        begin : g_div
            uvs_div_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .bands     (bands_reg),
                .meridians (meridians_reg),
                .tag_in    (cell_tag[gi]),
                .quo_in    (cell_quo[gi]),
                .tag_out   (cell_tag[gi+1]),
                .quo_out   (cell_quo[gi+1])
            );
        end
    endgenerate

    assign lat_ph = AW'(uvs_pkg::QUARTER
                        - cell_quo[uvs_pkg::DIV_STEPS].lat_quo[uvs_pkg::QUO_W-1:1]);
    assign lon_ph = cell_quo[uvs_pkg::DIV_STEPS].lon_quo[AW-1:0];

    uvs_sine u_sin_lat (.clk(clk), .en(en), .phase(lat_ph), .sine(sin_lat));
    uvs_sine u_cos_lat (.clk(clk), .en(en), .phase(AW'(lat_ph + uvs_pkg::QUARTER)),
                        .sine(cos_lat));
    uvs_sine u_sin_lon (.clk(clk), .en(en), .phase(lon_ph), .sine(sin_lon));
    uvs_sine u_cos_lon (.clk(clk), .en(en), .phase(AW'(lon_ph + uvs_pkg::QUARTER)),
                        .sine(cos_lon));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < uvs_pkg::SIN_STAGES; i++)
            begin
                sin_tag_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            sin_tag_reg[0] <= cell_tag[uvs_pkg::DIV_STEPS];
            for (int i = 1; i < uvs_pkg::SIN_STAGES; i++)
            begin
                sin_tag_reg[i] <= sin_tag_reg[i-1];
            end
        end
    end

    uvs_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .tag_in   (sin_tag_reg[uvs_pkg::SIN_STAGES-1]),
        .sin_lat  (sin_lat),
        .cos_lat  (cos_lat),
        .sin_lon  (sin_lon),
        .cos_lon  (cos_lon),
        .center_x (center_x_reg),
        .center_y (center_y_reg),
        .center_z (center_z_reg),
        .radius   (radius_reg),
        .valid    (vtx_valid),
        .item     (vtx_item)
    );

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        vtx_valid && vtx_item.index_error |-> vtx_item.last_vertex)
        else $error("error item is not the last vertex of its cell");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        vtx_valid && vtx_item.index_error |->
            vtx_item.pos_x == 0 && vtx_item.pos_y == 0 && vtx_item.pos_z == 0)
        else $error("error item carries a position");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> k_reg <= 3'd5)
        else $error("sequencer step out of range");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        vtx_valid && vtx_stall |=> $stable(k_reg))
        else $error("sequencer advanced while the result was stalled");

endmodule
